// ===== rtl/stereo_peak_tracker_pwm_dac_defines.svh =====
// ---------------------------------------------------------------------------
// Stereo peak tracker PWM DAC - assertion macros
// Concurrent check macros clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef STEREO_PEAK_TRACKER_PWM_DAC_DEFINES_SVH
`define STEREO_PEAK_TRACKER_PWM_DAC_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define SPTPD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sptpd check failed: same-cycle implication");
// antecedent implies consequent in the next cycle
`define SPTPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sptpd check failed: next-cycle implication");
`else
`define SPTPD_ASSERT_IMPLY(label, ante, cons)
`define SPTPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/sptpd_pkg.sv =====
// ---------------------------------------------------------------------------
// Stereo peak tracker PWM DAC - package
// Shared widths, reset values, command and register codes, pipeline types.
// ---------------------------------------------------------------------------
package sptpd_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int DUTY_W          = 17;
    localparam int GAIN_W          = 16;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 17;
    localparam int SAMPLE_BITS_DEF = 16;

    // signed offset (SAMPLE_W+1) times zero-extended gain (GAIN_W+1)
    localparam int PROD_W = SAMPLE_W + GAIN_W + 2;
    // center plus swing, with room for sign and overflow
    localparam int SUM_W  = DUTY_W + 3;

    localparam logic [DUTY_W-1:0] DUTY_CENTER_RST = DUTY_W'(33325);
    localparam logic [GAIN_W-1:0] DUTY_GAIN_RST   = GAIN_W'(16650);

    typedef enum logic [0:0] {
        CMD_SAMPLE    = 1'b0,
        CMD_PEAK_READ = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DUTY_CENTER = 1'b0,
        CFG_DUTY_GAIN   = 1'b1
    } cfg_index_t;

    // control into each lane for one accepted transaction
    typedef struct packed {
        logic take;
        logic peak_read;
    } lane_ctrl_t;

    // what a lane hands to the merge stage
    typedef struct packed {
        logic [PROD_W-1:0]   prod;
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] pmin;
        logic [SAMPLE_W-1:0] pmax;
    } lane_t;

    // control into the merge / output stage
    typedef struct packed {
        logic advance;
        logic peak_read;
    } merge_ctrl_t;

endpackage

// ===== rtl/sptpd_if.sv =====
// ---------------------------------------------------------------------------
// Stereo peak tracker PWM DAC - channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ---------------------------------------------------------------------------
interface sptpd_in_if import sptpd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [0:0]          command;
    logic [SAMPLE_W-1:0] sample_left;
    logic [SAMPLE_W-1:0] sample_right;

    modport source (output valid, command, sample_left, sample_right, input ready);
    modport sink   (input valid, command, sample_left, sample_right, output ready);
endinterface

interface sptpd_out_if import sptpd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DUTY_W-1:0]   duty_left;
    logic [DUTY_W-1:0]   duty_right;
    logic [SAMPLE_W-1:0] level_left;
    logic [SAMPLE_W-1:0] level_right;
    logic [SAMPLE_W-1:0] peak_min_left;
    logic [SAMPLE_W-1:0] peak_max_left;
    logic [SAMPLE_W-1:0] peak_min_right;
    logic [SAMPLE_W-1:0] peak_max_right;

    modport source (
        output valid, duty_left, duty_right, level_left, level_right,
               peak_min_left, peak_max_left, peak_min_right, peak_max_right,
        input  ready
    );
    modport sink (
        input  valid, duty_left, duty_right, level_left, level_right,
               peak_min_left, peak_max_left, peak_min_right, peak_max_right,
        output ready
    );
endinterface

interface sptpd_cfg_if import sptpd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/stereo_peak_tracker_pwm_dac.sv =====
// ---------------------------------------------------------------------------
// Stereo peak tracker PWM DAC - top level
// Each item transaction is either a stereo sample pair or a peak read. A
// sample pair is stored as the latest levels, folded into each channel's
// running min/max, and mapped to a PWM duty count per channel:
// duty_center + (sample - mid) * duty_gain / mid, truncated toward zero and
// clamped to 0..131071. A peak read returns the four extremes (duties read
// as zero) and then restarts the envelope (mins to full scale, maxes to 0).
// Every item gives exactly one result transaction. Throughput is one item
// per clock while results are being taken; each item passes through the
// two-stage pipeline: a per-channel lane registering the 17x17 gain
// product and envelope, then the merge stage doing scale, add and clamp
// into the output register. Only the low SAMPLE_BITS bits of each sample
// are used. Write configuration (index 0 duty_center, 1 duty_gain) only
// while no item is in flight; cfg is always ready.
// ---------------------------------------------------------------------------
`include "stereo_peak_tracker_pwm_dac_defines.svh"

module stereo_peak_tracker_pwm_dac import sptpd_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sptpd_in_if.sink    item,
    sptpd_out_if.source result,
    sptpd_cfg_if.sink   cfg
);

    // configuration registers
    logic [DUTY_W-1:0] center_reg, center_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;

    // stage 1 occupancy and command
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_read_reg, s1_read_next;

    logic        accept;
    logic        s1_advance;
    logic        is_read;
    lane_ctrl_t  lane_ctrl;
    merge_ctrl_t merge_ctrl;
    lane_t       left_res;
    lane_t       right_res;

    // ---------------------------------------------------------------
    // Configuration: always ready, written by index
    // ---------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_comb
    begin
        center_next = center_reg;
        gain_next   = gain_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_DUTY_CENTER: center_next = cfg.data;
                CFG_DUTY_GAIN:   gain_next   = cfg.data[GAIN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= DUTY_CENTER_RST;
            gain_reg   <= DUTY_GAIN_RST;
        end
        else
        begin
            center_reg <= center_next;
            gain_reg   <= gain_next;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control
    // Stage 1 moves into the output register whenever that register is
    // empty or being drained, and a new item is taken whenever stage 1 is
    // empty or advancing, even while a finished result still waits downstream.
    // ---------------------------------------------------------------
    assign s1_advance = s1_valid_reg && (!result.valid || result.ready);
    assign item.ready = !s1_valid_reg || s1_advance;
    assign accept     = item.valid && item.ready;
    assign is_read    = (item.command == CMD_PEAK_READ);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_read_next  = s1_read_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_read_next  = is_read;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_read_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_read_reg  <= s1_read_next;
        end
    end

    assign lane_ctrl.take       = accept;
    assign lane_ctrl.peak_read  = is_read;
    assign merge_ctrl.advance   = s1_advance;
    assign merge_ctrl.peak_read = s1_read_reg;

    // ---------------------------------------------------------------
    // Channel lanes
    // ---------------------------------------------------------------
    sptpd_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .sample (item.sample_left),
        .gain   (gain_reg),
        .res    (left_res)
    );

    sptpd_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .sample (item.sample_right),
        .gain   (gain_reg),
        .res    (right_res)
    );

    // ---------------------------------------------------------------
    // Merge: duty scaling and output register
    // ---------------------------------------------------------------
    sptpd_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (merge_ctrl),
        .left   (left_res),
        .right  (right_res),
        .center (center_reg),
        .result (result)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // a held stage 1 must never be overwritten by a new transaction
    `SPTPD_ASSERT_IMPLY(a_no_overrun, s1_valid_reg && !s1_advance, !accept)
    // whatever leaves stage 1 shows up on the output next cycle
    `SPTPD_ASSERT_NEXT(a_result_follows, s1_advance, result.valid)
    // a nonzero duty comes from a sample, which lies inside its own envelope
    `SPTPD_ASSERT_IMPLY(a_envelope_left, result.valid && (result.duty_left != '0), result.peak_min_left <= result.level_left && result.level_left <= result.peak_max_left)
    `SPTPD_ASSERT_IMPLY(a_envelope_right, result.valid && (result.duty_right != '0), result.peak_min_right <= result.level_right && result.level_right <= result.peak_max_right)

endmodule

// ===== rtl/sptpd_lane.sv =====
// ---------------------------------------------------------------------------
// Stereo peak tracker PWM DAC - channel lane
// Holds one channel's latest level and min/max envelope, and registers the
// gain product of the sample's signed offset from mid-scale.
// ---------------------------------------------------------------------------
module sptpd_lane import sptpd_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lane_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [GAIN_W-1:0]   gain,
    output lane_t               res
);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);
    localparam logic [SAMPLE_W:0]   SAMPLE_MID  = (SAMPLE_W + 1)'(33'd1 << (SAMPLE_BITS - 1));

    logic [SAMPLE_W-1:0]        latest_reg, latest_next;
    logic [SAMPLE_W-1:0]        low_reg, low_next;
    logic [SAMPLE_W-1:0]        high_reg, high_next;
    lane_t                      res_reg, res_next;

    logic [SAMPLE_W-1:0]        s;
    logic [SAMPLE_W-1:0]        low_upd;
    logic [SAMPLE_W-1:0]        high_upd;
    logic signed [SAMPLE_W:0]   offset;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [PROD_W-1:0]   prod;

    assign s        = sample & SAMPLE_MASK;
    assign low_upd  = (s < low_reg)  ? s : low_reg;
    assign high_upd = (s > high_reg) ? s : high_reg;
    assign offset   = $signed({1'b0, s}) - $signed(SAMPLE_MID);
    assign gain_s   = $signed({1'b0, gain});
    assign prod     = offset * gain_s;

    always_comb
    begin
        latest_next = latest_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        res_next    = res_reg;
        if (ctrl.take)
        begin
            if (ctrl.peak_read)
            begin
                // report the envelope, then restart it
                res_next.prod  = '0;
                res_next.level = latest_reg;
                res_next.pmin  = low_reg;
                res_next.pmax  = high_reg;
                low_next       = SAMPLE_MASK;
                high_next      = '0;
            end
            else
            begin
                res_next.prod  = prod;
                res_next.level = s;
                res_next.pmin  = low_upd;
                res_next.pmax  = high_upd;
                latest_next    = s;
                low_next       = low_upd;
                high_next      = high_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg <= '0;
            low_reg    <= SAMPLE_MASK;
            high_reg   <= '0;
        end
        else
        begin
            latest_reg <= latest_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/sptpd_merge.sv =====
// ---------------------------------------------------------------------------
// Stereo peak tracker PWM DAC - merge and output stage
// Scales both lane products to duty counts, saturates, and registers the
// combined result transaction toward the output channel.
// ---------------------------------------------------------------------------
module sptpd_merge import sptpd_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  merge_ctrl_t       ctrl,
    input  lane_t             left,
    input  lane_t             right,
    input  logic [DUTY_W-1:0] center,
    sptpd_out_if.source       result
);

    localparam int SHIFT = SAMPLE_BITS - 1;
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'((64'd1 << SHIFT) - 64'd1);

    // center + product / mid-scale, truncated toward zero, clamped to duty range
    function automatic logic [DUTY_W-1:0] scale_duty(
        input logic [PROD_W-1:0] prod,
        input logic [DUTY_W-1:0] ctr
    );
        logic [PROD_W-1:0]        biased;
        logic signed [PROD_W-1:0] swing;
        logic signed [SUM_W-1:0]  sum;
        logic [DUTY_W-1:0]        duty;
        biased = prod + (prod[PROD_W-1] ? ROUND_BIAS : '0);
        swing  = $signed(biased) >>> SHIFT;
        sum    = $signed({{(SUM_W - DUTY_W){1'b0}}, ctr}) + $signed(swing[SUM_W-1:0]);
        if (sum[SUM_W-1])
            duty = '0;
        else if (sum[SUM_W-2:DUTY_W] != '0)
            duty = '1;
        else
            duty = sum[DUTY_W-1:0];
        return duty;
    endfunction

    logic                valid_reg, valid_next;
    logic [DUTY_W-1:0]   duty_l_reg, duty_r_reg;
    logic [SAMPLE_W-1:0] lvl_l_reg, lvl_r_reg;
    logic [SAMPLE_W-1:0] min_l_reg, max_l_reg, min_r_reg, max_r_reg;

    always_comb
    begin
        if (ctrl.advance)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            duty_l_reg <= ctrl.peak_read ? '0 : scale_duty(left.prod, center);
            duty_r_reg <= ctrl.peak_read ? '0 : scale_duty(right.prod, center);
            lvl_l_reg  <= left.level;
            lvl_r_reg  <= right.level;
            min_l_reg  <= left.pmin;
            max_l_reg  <= left.pmax;
            min_r_reg  <= right.pmin;
            max_r_reg  <= right.pmax;
        end
    end

    assign result.valid          = valid_reg;
    assign result.duty_left      = duty_l_reg;
    assign result.duty_right     = duty_r_reg;
    assign result.level_left     = lvl_l_reg;
    assign result.level_right    = lvl_r_reg;
    assign result.peak_min_left  = min_l_reg;
    assign result.peak_max_left  = max_l_reg;
    assign result.peak_min_right = min_r_reg;
    assign result.peak_max_right = max_r_reg;

endmodule

// ===== bench/stereo_peak_tracker_pwm_dac_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stereo peak tracker PWM DAC - scoreboard
// Watches the item, result and cfg channels and keeps its own copy of the
// envelope state and duty settings. Each accepted item queues the result it
// should produce; each accepted result is compared field by field with the
// oldest queued entry.
// ---------------------------------------------------------------------------
module stereo_peak_tracker_pwm_dac_chk import sptpd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    sptpd_in_if   item,
    sptpd_out_if  result,
    sptpd_cfg_if  cfg,
    output int    fail_count,
    output int    outstanding
);

    localparam longint MID      = longint'(1) << (SAMPLE_W - 1);
    localparam longint DUTY_TOP = (longint'(1) << DUTY_W) - 1;

    typedef struct {
        logic [DUTY_W-1:0]   duty_l;
        logic [DUTY_W-1:0]   duty_r;
        logic [SAMPLE_W-1:0] level_l;
        logic [SAMPLE_W-1:0] level_r;
        logic [SAMPLE_W-1:0] min_l;
        logic [SAMPLE_W-1:0] max_l;
        logic [SAMPLE_W-1:0] min_r;
        logic [SAMPLE_W-1:0] max_r;
    } envelope_t;

    logic [DUTY_W-1:0]   center_q;
    logic [GAIN_W-1:0]   gain_q;
    logic [SAMPLE_W-1:0] last_l;
    logic [SAMPLE_W-1:0] last_r;
    logic [SAMPLE_W-1:0] low_l;
    logic [SAMPLE_W-1:0] high_l;
    logic [SAMPLE_W-1:0] low_r;
    logic [SAMPLE_W-1:0] high_r;

    envelope_t envelope_q[$];

    initial fail_count = 0;
    initial outstanding = 0;

    task automatic report(string msg);
        fail_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [DUTY_W-1:0] got,
                               logic [DUTY_W-1:0] want);
        if (got !== want)
            report($sformatf("%s mismatch: got %0d, want %0d", name, got, want));
    endtask

    // exact integer duty: center + trunc((s - mid) * gain / mid), clamped
    function automatic logic [DUTY_W-1:0] pwm_duty(logic [SAMPLE_W-1:0] s);
        longint offset;
        longint swing;
        longint sum;
        offset = longint'(s) - MID;
        swing  = (offset * longint'(gain_q)) / MID;
        sum    = longint'(center_q) + swing;
        if (sum < 0)
            sum = 0;
        if (sum > DUTY_TOP)
            sum = DUTY_TOP;
        return DUTY_W'(sum);
    endfunction

    function automatic envelope_t track_envelope(cmd_t cmd, logic [SAMPLE_W-1:0] sl,
                                                 logic [SAMPLE_W-1:0] sr);
        envelope_t e;
        e.duty_l = '0;
        e.duty_r = '0;
        if (cmd == CMD_SAMPLE)
        begin
            last_l = sl;
            last_r = sr;
            if (sl < low_l)  low_l  = sl;
            if (sl > high_l) high_l = sl;
            if (sr < low_r)  low_r  = sr;
            if (sr > high_r) high_r = sr;
            e.duty_l = pwm_duty(sl);
            e.duty_r = pwm_duty(sr);
        end
        e.level_l = last_l;
        e.level_r = last_r;
        e.min_l   = low_l;
        e.max_l   = high_l;
        e.min_r   = low_r;
        e.max_r   = high_r;
        if (cmd == CMD_PEAK_READ)
        begin
            low_l  = '1;
            high_l = '0;
            low_r  = '1;
            high_r = '0;
        end
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        envelope_t got;
        envelope_t want;
        if (!rst_n)
        begin
            center_q = DUTY_CENTER_RST;
            gain_q   = DUTY_GAIN_RST;
            last_l   = '0;
            last_r   = '0;
            low_l    = '1;
            high_l   = '0;
            low_r    = '1;
            high_r   = '0;
            envelope_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_DUTY_CENTER: center_q = cfg.data;
                    CFG_DUTY_GAIN:   gain_q   = cfg.data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                if (envelope_q.size() == 0)
                    report("result transaction with nothing expected");
                else
                begin
                    want = envelope_q.pop_front();
                    got.duty_l  = result.duty_left;
                    got.duty_r  = result.duty_right;
                    got.level_l = result.level_left;
                    got.level_r = result.level_right;
                    got.min_l   = result.peak_min_left;
                    got.max_l   = result.peak_max_left;
                    got.min_r   = result.peak_min_right;
                    got.max_r   = result.peak_max_right;
                    check_field("duty_left", got.duty_l, want.duty_l);
                    check_field("duty_right", got.duty_r, want.duty_r);
                    check_field("level_left", DUTY_W'(got.level_l),
                                DUTY_W'(want.level_l));
                    check_field("level_right", DUTY_W'(got.level_r),
                                DUTY_W'(want.level_r));
                    check_field("peak_min_left", DUTY_W'(got.min_l),
                                DUTY_W'(want.min_l));
                    check_field("peak_max_left", DUTY_W'(got.max_l),
                                DUTY_W'(want.max_l));
                    check_field("peak_min_right", DUTY_W'(got.min_r),
                                DUTY_W'(want.min_r));
                    check_field("peak_max_right", DUTY_W'(got.max_r),
                                DUTY_W'(want.max_r));
                end
            end

            if (item.valid && item.ready)
                envelope_q.push_back(track_envelope(cmd_t'(item.command),
                                                    item.sample_left, item.sample_right));
        end
        outstanding = envelope_q.size();
    end

endmodule

// ===== bench/stereo_peak_tracker_pwm_dac_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stereo peak tracker PWM DAC - testbench top
// Drives sample pairs and peak reads into the tracker under several duty
// settings and handshake pressure patterns; the scoreboard beside the block
// checks every result and hands back a failure count for the verdict.
// ---------------------------------------------------------------------------
module stereo_peak_tracker_pwm_dac_tb import sptpd_pkg::*; ();

    // cycles with no transaction on any channel before the run is abandoned
    localparam int QUIET_LIMIT = 5000;
    // items per random segment; six segments give about 1900 items
    localparam int SEG_ITEMS   = 315;

    logic clk;
    logic rst_n;

    sptpd_in_if  item_ch ();
    sptpd_out_if result_ch ();
    sptpd_cfg_if cfg_ch ();

    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int fail_count;
    int outstanding;

    stereo_peak_tracker_pwm_dac u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    stereo_peak_tracker_pwm_dac_chk u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure: a fresh coin per cycle, changed on the
    // falling edge so the block sees a settled ready at the rising edge.
    initial result_ch.ready = 1'b0;
    always @(negedge clk)
        result_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                 (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One item transaction. Called at a falling edge, returns at the falling
    // edge after acceptance with valid still high, so back-to-back items keep
    // valid asserted without a drop in between.
    task automatic push_item(cmd_t cmd, logic [SAMPLE_W-1:0] left,
                             logic [SAMPLE_W-1:0] right);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.command      <= cmd;
        item_ch.sample_left  <= left;
        item_ch.sample_right <= right;
        do
            @(posedge clk);
        while (!item_ch.ready);
        @(negedge clk);
    endtask

    // Stop sending and hold until the scoreboard has seen every result.
    // At least one falling edge passes, so valid is never lowered and
    // raised in the same step.
    task automatic drain;
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    // Both registers in one burst: valid stays high across the two writes.
    // Only called right after drain, with the block idle.
    task automatic apply_settings(logic [DUTY_W-1:0] center, logic [GAIN_W-1:0] gain);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_DUTY_CENTER;
        cfg_ch.data  <= center;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.index <= CFG_DUTY_GAIN;
        cfg_ch.data  <= CFG_DATA_W'(gain);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Samples lean toward the rails and mid-scale, where the clamp and the
    // truncation toward zero matter most.
    function automatic logic [SAMPLE_W-1:0] pick_sample;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'(32768 + $urandom_range(0, 8) - 4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        item_ch.valid        = 1'b0;
        item_ch.command      = CMD_SAMPLE;
        item_ch.sample_left  = '0;
        item_ch.sample_right = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_DUTY_CENTER;
        cfg_ch.data          = '0;
        send_idle_pct        = 36;
        recv_idle_pct        = 63;
        rst_n                = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed: reset settings ----
        // read with nothing tracked yet: mins sit above maxes
        push_item(CMD_PEAK_READ, '0, '0);
        push_item(CMD_SAMPLE, 16'h0000, 16'hFFFF);
        push_item(CMD_SAMPLE, 16'hFFFF, 16'h0000);
        // mid-scale gives the center duty exactly
        push_item(CMD_SAMPLE, 16'h8000, 16'h8000);
        // one below mid: -0.5 count truncates to zero, not -1
        push_item(CMD_SAMPLE, 16'h7FFF, 16'h8001);
        push_item(CMD_SAMPLE, 16'h0001, 16'hFFFE);
        push_item(CMD_PEAK_READ, 16'hFFFF, 16'hFFFF);
        // back-to-back read reports the cleared envelope, levels unchanged
        push_item(CMD_PEAK_READ, '0, '0);
        push_item(CMD_SAMPLE, 16'h5555, 16'hAAAA);
        push_item(CMD_SAMPLE, 16'hAAAA, 16'h5555);
        push_item(CMD_PEAK_READ, 16'h1234, 16'h4321);

        // ---- directed: zero center, full gain -> clamp at the bottom ----
        drain();
        apply_settings('0, '1);
        push_item(CMD_SAMPLE, 16'h0000, 16'h7FFF);
        push_item(CMD_SAMPLE, 16'hFFFF, 16'h8000);
        push_item(CMD_PEAK_READ, '0, '0);

        // ---- directed: full center, full gain -> clamp at the top ----
        drain();
        apply_settings('1, '1);
        push_item(CMD_SAMPLE, 16'hFFFF, 16'h0000);
        push_item(CMD_SAMPLE, 16'h8001, 16'h7FFF);
        push_item(CMD_PEAK_READ, '0, '0);

        // ---- directed: zero gain -> duty stuck at center ----
        drain();
        apply_settings(DUTY_W'(70000), '0);
        push_item(CMD_SAMPLE, 16'h0000, 16'hFFFF);
        push_item(CMD_PEAK_READ, '0, '0);

        // ---- random segments ----
        // segments 0-1: sender idles less, receiver more; 2-3 the reverse;
        // 4-5 both sides at full rate
        for (int seg = 0; seg < 6; seg++)
        begin
            drain();
            case (seg / 2)
                0: begin send_idle_pct = 36; recv_idle_pct = 63; end
                1: begin send_idle_pct = 63; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (seg)
                0: apply_settings(DUTY_W'($urandom_range(0, 131071)),
                                  GAIN_W'($urandom_range(0, 65535)));
                1: apply_settings('0, '1);
                2: apply_settings('1, '1);
                3: apply_settings(DUTY_CENTER_RST, DUTY_GAIN_RST);
                4: apply_settings(DUTY_W'($urandom_range(0, 131071)), '0);
                default: apply_settings(DUTY_W'($urandom_range(0, 131071)),
                                        GAIN_W'($urandom_range(0, 65535)));
            endcase
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // halfway through, let the pipeline run dry before going on
                if (n == SEG_ITEMS / 2)
                    drain();
                // roughly one peak read per dozen transactions keeps the
                // envelope both fresh and well populated
                push_item(($urandom_range(0, 11) == 0) ? CMD_PEAK_READ : CMD_SAMPLE,
                          pick_sample(), pick_sample());
            end
        end

        drain();
        // spare cycles after the drain catch any stray result
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
